### src/waas_pkg.sv
// Package for the wrap-aware angle speed block: widths, scale constant, state codes.
// Depends on nothing; every other file uses it.
`timescale 1ns / 1ps
`default_nettype none
package waas_pkg;

    localparam int ANGLE_BITS  = 12;
    localparam int TIME_BITS   = 32;
    localparam int SPEED_WIDTH = 37;
    localparam int DELTA_WIDTH = ANGLE_BITS + 1;

    // 360 deg * 1e6 us/s * 256 (Q8), spread over one turn of ticks
    localparam logic [63:0] DEG_US_Q8 = 64'd92160000000;
    localparam logic [63:0] K_SCALE   = DEG_US_Q8 >> ANGLE_BITS;
    localparam int          K_BITS    = $clog2(K_SCALE + 64'd1);

    // Product of the tick magnitude (at most half a turn) and the scale
    localparam int PROD_BITS = ANGLE_BITS + K_BITS;
    localparam int CNT_BITS  = $clog2(PROD_BITS + 1);

    // Sequencer codes
    localparam int ST_BITS = 3;
    localparam logic [ST_BITS-1:0] S_IDLE  = 3'd0;
    localparam logic [ST_BITS-1:0] S_MUL   = 3'd1;
    localparam logic [ST_BITS-1:0] S_START = 3'd2;
    localparam logic [ST_BITS-1:0] S_WAIT  = 3'd3;
    localparam logic [ST_BITS-1:0] S_OUT   = 3'd4;

    typedef logic [ANGLE_BITS-1:0]         t_angle;
    typedef logic [TIME_BITS-1:0]          t_time;
    typedef logic [PROD_BITS-1:0]          t_prod;
    typedef logic signed [SPEED_WIDTH-1:0] t_speed;
    typedef logic signed [DELTA_WIDTH-1:0] t_delta;

endpackage
`default_nettype wire

### src/waas_if.sv
// Channel interfaces for the angle speed block: input sample beats and result beats.
// Depends on waas_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface waas_in_if;
    logic               valid;
    logic               ready;
    waas_pkg::t_angle   angle_ticks;
    waas_pkg::t_time    time_us;

    modport source (output valid, output angle_ticks, output time_us, input ready);
    modport sink   (input valid, input angle_ticks, input time_us, output ready);
endinterface

interface waas_out_if;
    logic               valid;
    logic               ready;
    waas_pkg::t_speed   speed_dps_q8;
    waas_pkg::t_delta   delta_ticks;
    logic               ok;

    modport source (output valid, output speed_dps_q8, output delta_ticks, output ok,
                    input ready);
    modport sink   (input valid, input speed_dps_q8, input delta_ticks, input ok,
                    output ready);
endinterface
`default_nettype wire

### src/wrap_aware_angle_speed.sv
// Top level of the wrap-aware angle speed estimator: sequencer, state, output register.
// Depends on waas_pkg, waas_if (channel interfaces) and waas_div.
//
//   Channel  Dir  Beat contents                              Handshake
//   i_in     in   angle_ticks[11:0], time_us[31:0]           valid / ready
//   o_out    out  speed_dps_q8[36:0] s, delta_ticks[12:0] s,  valid / ready
//                 ok
//
// Each sample passes through capture of the tick and time deltas, the scale multiply,
// the divider launch, the bit-serial divide and write-back before the next beat is
// accepted. A zero time delta skips the multiply and divide and goes straight
// to write-back. i_in.ready is high only while the sequencer is idle; the divider
// sets the rate unless a stalled o_out holds the sequencer in write-back.
// Reset (i_rst_n, synchronous, active low) clears previous angle and time to zero.
// A result waiting on a stalled o_out does not block the next sample's capture; the
// sequencer holds in write-back only when a second result is ready behind it.
`timescale 1ns / 1ps
`default_nettype none
module wrap_aware_angle_speed (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    waas_in_if.sink     i_in,
    waas_out_if.source  o_out
);
    import waas_pkg::*;

    localparam t_angle HALF = t_angle'(1) << (ANGLE_BITS - 1);

    logic [ST_BITS-1:0] r_state, n_state;

    t_angle  r_prev_angle;
    t_time   r_prev_time;

    // Per-sample working registers
    t_angle  r_cur;
    t_time   r_now;
    t_angle  r_mag;
    logic    r_neg;
    logic    r_zero;
    t_time   r_dt;
    t_prod   r_prod;

    // Output register
    logic    r_out_valid;
    t_speed  r_speed;
    t_delta  r_delta;
    logic    r_ok;

    t_angle  d;
    t_time   dt;
    t_angle  mag;
    logic    neg;
    logic    accept;
    logic    out_free;
    logic    div_start;
    logic    div_done;
    t_prod   quot;
    t_speed  speed_mag;

    // Shortest-path tick change; an exact half turn takes its sign from the compare
    assign d   = i_in.angle_ticks - r_prev_angle;
    assign dt  = i_in.time_us - r_prev_time;
    assign mag = (d > HALF) ? t_angle'(-d) : d;
    assign neg = (d > HALF) || ((d == HALF) && (i_in.angle_ticks < r_prev_angle));

    assign accept    = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;
    assign div_start = (r_state == S_START);

    waas_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_dt),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    assign speed_mag = SPEED_WIDTH'(quot);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (dt == '0) ? S_OUT : S_MUL;
                end
            end
            S_MUL:   n_state = S_START;
            S_START: n_state = S_WAIT;
            S_WAIT: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prev_angle <= '0;
            r_prev_time  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            // Load a new result beat, or drop the current one once taken
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
                // Advance the stored sample only on a valid speed
                if (!r_zero) begin
                    r_prev_angle <= r_cur;
                    r_prev_time  <= r_now;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur  <= i_in.angle_ticks;
            r_now  <= i_in.time_us;
            r_mag  <= mag;
            r_neg  <= neg;
            r_zero <= (dt == '0);
            r_dt   <= dt;
        end
        if (r_state == S_MUL) begin
            r_prod <= PROD_BITS'(r_mag) * PROD_BITS'(K_SCALE);
        end
        if ((r_state == S_OUT) && out_free) begin
            if (r_zero) begin
                r_speed <= '0;
                r_delta <= '0;
                r_ok    <= 1'b0;
            end else begin
                r_speed <= r_neg ? -speed_mag : speed_mag;
                r_delta <= r_neg ? -t_delta'({1'b0, r_mag}) : t_delta'({1'b0, r_mag});
                r_ok    <= 1'b1;
            end
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.speed_dps_q8  = r_speed;
    assign o_out.delta_ticks   = r_delta;
    assign o_out.ok            = r_ok;

endmodule
`default_nettype wire

### src/waas_div.sv
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// Depends on waas_pkg.
`timescale 1ns / 1ps
`default_nettype none
module waas_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire waas_pkg::t_prod  i_dividend,
    input  wire waas_pkg::t_time  i_divisor,
    output logic                  o_done,
    output waas_pkg::t_prod       o_quot
);
    import waas_pkg::*;

    logic                 r_busy;
    logic [CNT_BITS-1:0]  r_cnt;
    t_prod                r_quo;
    t_time                r_rem;
    t_time                r_dvs;
    logic [TIME_BITS:0]   trial;
    logic                 take;

    // Shift the next dividend bit into the partial remainder and try a subtract
    assign trial = {r_rem, r_quo[PROD_BITS-1]};
    assign take  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_BITS'(PROD_BITS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[PROD_BITS-2:0], take};
            r_rem <= take ? TIME_BITS'(trial - {1'b0, r_dvs}) : trial[TIME_BITS-1:0];
        end
    end

    assign o_done = r_busy && (r_cnt == CNT_BITS'(1));
    assign o_quot = r_quo;

endmodule
`default_nettype wire

### src/waas_chk.sv
// Port-level checker for the angle speed block, bound to the top level.
// Depends on waas_pkg.
`timescale 1ns / 1ps
`default_nettype none
module waas_chk (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic              i_out_valid,
    input wire waas_pkg::t_speed  i_speed,
    input wire waas_pkg::t_delta  i_delta,
    input wire logic              i_ok
);
    import waas_pkg::*;

    // One sample at a time: busy right after a beat is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after accepted beat");

    // A zero time delta reports zeros
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_ok) |-> (i_speed == '0 && i_delta == '0))
        else $error("error result with nonzero fields");

    // No motion, no speed
    a_still_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_ok && i_delta == '0) |-> (i_speed == '0))
        else $error("speed nonzero with zero delta");

    // Speed never takes the opposite sign of the tick change
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_ok) |->
            ((i_delta > 0 && !i_speed[SPEED_WIDTH-1]) ||
             (i_delta < 0 && i_speed <= 0) || (i_delta == '0)))
        else $error("speed sign disagrees with delta");

endmodule

bind wrap_aware_angle_speed waas_chk u_waas_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_speed     (o_out.speed_dps_q8),
    .i_delta     (o_out.delta_ticks),
    .i_ok        (o_out.ok)
);
`default_nettype wire
